>>> design/kbit_pattern_coverage_checker_assert.svh
// Assertion macros for the k-bit pattern coverage checker.
// Used by the checker module; relies on clock and reset signals in scope.
`ifndef KBIT_PATTERN_COVERAGE_CHECKER_ASSERT_SVH
`define KBIT_PATTERN_COVERAGE_CHECKER_ASSERT_SVH

// Property checked only outside reset
`define KPCC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included
`define KPCC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/kpcc_pkg.sv
// Shared types and constants for the k-bit pattern coverage checker.
// No dependencies; imported by every module of the block.
package kpcc_pkg;

   // Code length and derived sizes
   localparam int MAX_CODE_BITS = 16;
   localparam int KLEN_W        = 5;
   localparam int CNT_W         = MAX_CODE_BITS + 1;
   localparam int BITS_W        = $clog2(MAX_CODE_BITS + 1);
   localparam int MAP_DEPTH     = 1 << MAX_CODE_BITS;

   // String tag stored per bitmap entry; zero means never seen
   localparam int                EPOCH_W     = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified request
   typedef struct packed {
      logic [MAX_CODE_BITS-1:0] code;
      logic                     mark;
      logic                     last;
      logic [KLEN_W-1:0]        kval;
   } item_type;

   // Back end sequencer
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   // Status from back end to top
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> design/kbit_pattern_coverage_checker.sv
// A request accepted passes through the queue slot, the back-end stage register and the response register.
// Throughput: one request per cycle while req_stall is low, bitmap read-modify-write in the back end.
// Every 255th completed string, a bitmap sweep holds off requests.
// Reset (synchronous): window_len = 1, control state cleared, then a sweep of
// the bitmap during which req_stall stays high.
// Depends on kpcc_pkg, kpcc_front, kpcc_queue, kpcc_back.
module kbit_pattern_coverage_checker import kpcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [KLEN_W-1:0] csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_bit_in,
   input  logic              req_end_of_string,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CNT_W-1:0]  rsp_distinct_codes,
   output logic              rsp_all_covered,
   output logic              rsp_final_result
);

   logic [KLEN_W-1:0] window_len_ff;
   logic              req_accept;
   item_type          front_item, head_item;
   logic              q_full, q_not_empty, q_pop;
   back_status_type   back_status;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= KLEN_W'(1);
      end else if (csr_write_enable) begin
         window_len_ff <= csr_write_data;
      end
   end

   assign req_stall  = q_full || back_status.clearing;
   assign req_accept = req_valid && !req_stall;

   kpcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .bit_in     (req_bit_in),
      .last       (req_end_of_string),
      .window_len (window_len_ff),
      .item       (front_item)
   );

   kpcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   kpcc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_not_empty),
      .q_item             (head_item),
      .q_pop              (q_pop),
      .status             (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distinct_codes (rsp_distinct_codes),
      .rsp_all_covered    (rsp_all_covered),
      .rsp_final_result   (rsp_final_result)
   );

endmodule

>>> design/kpcc_front.sv
// Front end: shift window, bit count and code classification per request.
// Depends on kpcc_pkg.
module kpcc_front import kpcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              bit_in,
   input  logic              last,
   input  logic [KLEN_W-1:0] window_len,
   output item_type          item
);

   logic [MAX_CODE_BITS-1:0] window_ff, window_in;
   logic [BITS_W-1:0]        bits_ff, bits_in;
   logic [KLEN_W-1:0]        k_eff;
   logic [CNT_W-1:0]         code_mask;

   // Clamp the configured length to 1..MAX_CODE_BITS
   always_comb begin
      if (window_len == '0) begin
         k_eff = KLEN_W'(1);
      end else if (window_len > KLEN_W'(MAX_CODE_BITS)) begin
         k_eff = KLEN_W'(MAX_CODE_BITS);
      end else begin
         k_eff = window_len;
      end
   end

   // New window and saturating bit count for this request
   always_comb begin
      window_in = {window_ff[MAX_CODE_BITS-2:0], bit_in};
      if (bits_ff < BITS_W'(MAX_CODE_BITS)) begin
         bits_in = bits_ff + BITS_W'(1);
      end else begin
         bits_in = bits_ff;
      end
      code_mask = (CNT_W'(1) << k_eff) - CNT_W'(1);
   end

   // Classify: code only counts once k bits have arrived
   always_comb begin
      item.code = window_in & code_mask[MAX_CODE_BITS-1:0];
      item.mark = (CNT_W'(bits_in) >= CNT_W'(k_eff));
      item.last = last;
      item.kval = k_eff;
   end

   // Window state, cleared after the final bit
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         bits_ff   <= '0;
      end else if (accept) begin
         if (last) begin
            window_ff <= '0;
            bits_ff   <= '0;
         end else begin
            window_ff <= window_in;
            bits_ff   <= bits_in;
         end
      end
   end

endmodule

>>> design/kpcc_queue.sv
// Short FIFO of classified requests between front and back ends.
// Depends on kpcc_pkg.
module kpcc_queue import kpcc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head_item
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Occupancy update
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> design/kpcc_back.sv
// Back end: seen bitmap (string-tagged), distinct count, result register.
// Depends on kpcc_pkg; fed by kpcc_queue.
module kpcc_back import kpcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output back_status_type   status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CNT_W-1:0]  rsp_distinct_codes,
   output logic              rsp_all_covered,
   output logic              rsp_final_result
);

   // Bitmap: each entry holds the tag of the string that last set it
   logic [EPOCH_W-1:0]       seen_mem [MAP_DEPTH];

   state_type                state_ff, state_in;
   logic [MAX_CODE_BITS-1:0] clr_addr_ff;
   logic [EPOCH_W-1:0]       epoch_ff;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     b_valid_ff;
   item_type                 b_item_ff;
   logic                     b_fwd_ff, b_fwd_in;
   logic [EPOCH_W-1:0]       rdata_ff;

   logic                     rsp_valid_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_cover_ff;
   logic                     rsp_final_ff;

   logic                     clearing, clr_done;
   logic                     out_free, b_adv, b_free, wrap_hold;
   logic                     is_new, cover_now;
   logic [CNT_W-1:0]         full_count;
   logic                     mem_we;
   logic [MAX_CODE_BITS-1:0] mem_waddr;
   logic [EPOCH_W-1:0]       mem_wdata;

   assign clr_done = (clr_addr_ff == MAX_CODE_BITS'(MAP_DEPTH - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_done) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (b_adv && b_item_ff.last && (epoch_ff == EPOCH_LAST)) begin
               state_in = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs
   always_comb begin
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b1;
      endcase
   end

   assign status.clearing = clearing;

   // Pipeline flow
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign b_adv     = b_valid_ff && out_free;
   assign b_free    = !b_valid_ff || b_adv;
   // Hold the next string back while the tag space is about to wrap
   assign wrap_hold = b_valid_ff && b_item_ff.last && (epoch_ff == EPOCH_LAST);
   assign q_pop     = q_valid && b_free && !clearing && !wrap_hold;

   // Same code written by the item ahead in the cycle of this read
   assign b_fwd_in = b_valid_ff && b_item_ff.mark && !b_item_ff.last
                     && (b_item_ff.code == q_item.code);

   // Hit test and count update
   always_comb begin
      is_new     = b_item_ff.mark && !((rdata_ff == epoch_ff) || b_fwd_ff);
      count_in   = count_ff + CNT_W'(is_new);
      full_count = CNT_W'(1) << b_item_ff.kval;
      cover_now  = (count_in == full_count);
   end

   // Memory write port: sweep or marking
   always_comb begin
      if (clearing) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = EPOCH_NONE;
      end else begin
         mem_we    = b_adv && b_item_ff.mark;
         mem_waddr = b_item_ff.code;
         mem_wdata = epoch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rdata_ff <= seen_mem[q_item.code];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         epoch_ff     <= EPOCH_FIRST;
         count_ff     <= '0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clr_addr_ff <= clr_addr_ff + MAX_CODE_BITS'(1);
            if (clr_done) begin
               epoch_ff <= EPOCH_FIRST;
            end
         end
         if (b_adv) begin
            if (b_item_ff.last) begin
               count_ff <= '0;
               if (epoch_ff != EPOCH_LAST) begin
                  epoch_ff <= epoch_ff + EPOCH_W'(1);
               end
            end else begin
               count_ff <= count_in;
            end
         end
         if (q_pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= b_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff <= q_item;
         b_fwd_ff  <= b_fwd_in;
      end
      if (b_adv) begin
         rsp_count_ff <= count_in;
         rsp_cover_ff <= cover_now;
         rsp_final_ff <= b_item_ff.last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_codes = rsp_count_ff;
   assign rsp_all_covered    = rsp_cover_ff;
   assign rsp_final_result   = rsp_final_ff;

endmodule

>>> design/kpcc_checker.sv
// Port-level assertions for the k-bit pattern coverage checker, with bind.
// Depends on kpcc_pkg and kbit_pattern_coverage_checker_assert.svh.
`include "kbit_pattern_coverage_checker_assert.svh"

module kpcc_checker import kpcc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [CNT_W-1:0] rsp_distinct_codes,
   input logic             rsp_all_covered
);

   // A stalled response stays offered
   `KPCC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "response dropped under stall")

   // Count never exceeds the largest code space
   `KPCC_ASSERT(a_count_range, rsp_valid |-> (rsp_distinct_codes <= CNT_W'(MAP_DEPTH)), "distinct count out of range")

   // Full coverage needs at least one code
   `KPCC_ASSERT(a_cover_nonzero, rsp_valid && rsp_all_covered |-> (rsp_distinct_codes != '0), "coverage with zero codes")

   // Reset empties the output and starts the bitmap sweep
   `KPCC_ASSERT_ALWAYS(a_reset_state, reset |=> !rsp_valid && req_stall, "bad state after reset")

endmodule

bind kbit_pattern_coverage_checker kpcc_checker u_kpcc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_distinct_codes (rsp_distinct_codes),
   .rsp_all_covered    (rsp_all_covered)
);
